// ----- hdl/descending_sorted_key_table_top_macros.svh -----
// Assertion macros used by the sorted key table top level.
`ifndef DESCENDING_SORTED_KEY_TABLE_TOP_MACROS_SVH
`define DESCENDING_SORTED_KEY_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on a given clock and active-low reset.
`define DSKT_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
// Check a property on clk and rst_n.
`define DSKT_ASSERT(lbl, prop, msg) `DSKT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define DSKT_ASSERT_CLK(lbl, ck, rstn, prop, msg)
`define DSKT_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- hdl/dskt_pkg.sv -----
// Types and constants of the sorted key table.
package dskt_pkg;

    localparam int FUNC_W        = 2;
    localparam int ID_W          = 32;
    localparam int SCORE_W       = 16;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_LIST   = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_LIST      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    key_id;
        logic [SCORE_W-1:0] score;
    } cell_cmd_t;

endpackage

// ----- hdl/dskt_if.sv -----
// Request and result channel interfaces of the sorted key table.
interface dskt_req_if import dskt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     key_id;
    logic [SCORE_W-1:0]  score;

    modport source (output valid, func, key_id, score, input ready);
    modport sink   (input valid, func, key_id, score, output ready);
endinterface

interface dskt_rsp_if import dskt_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     entry_valid;
    logic [ID_W-1:0]          entry_id;
    logic [SCORE_W-1:0]       entry_score;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     last;

    modport source (output valid, status, entry_valid, entry_id, entry_score, entry_count,
                    last, input ready);
    modport sink   (input valid, status, entry_valid, entry_id, entry_score, entry_count,
                    last, output ready);
endinterface

// ----- hdl/descending_sorted_key_table_top.sv -----
// Top level of the sorted key table: cell chain, operation control and result register.
//
// The table holds up to DEPTH (id, score) entries in a chain of cells ordered by
// descending score; cell 0 holds the highest score, and a new entry goes behind
// existing entries of equal score. Each request transaction is one of insert,
// remove (first entry with a matching id) or list; func value 3 is dropped with no
// result. Insert and remove shift the whole chain at once, and the
// single result transaction sits in the output register in the next cycle. A list
// of n entries gives n result transactions, one per cycle while the result side
// takes them, by rotating the occupied part of the chain through cell 0; after n
// rotations the chain is back in order. A list of an empty table gives a single
// result with entry_valid low. The next request is taken once the last result of
// the current one is in the output register. Remove finds the first match through
// a one-bit carry that ripples along the chain. There is no clearing pass after
// reset: an entry count marks which cells hold data.
module descending_sorted_key_table_top import dskt_pkg::*; #(
    parameter int DEPTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    dskt_req_if.sink   req,
    dskt_rsp_if.source rsp
);

`include "descending_sorted_key_table_top_macros.svh"

    localparam int                 COUNT_W    = $clog2(DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);
    localparam logic [COUNT_W-1:0] ONE        = COUNT_W'(1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic [COUNT_W-1:0]       remain_reg;
    logic [COUNT_W-1:0]       remain_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    status_t                  out_status_next;
    logic                     out_entry_valid_reg;
    logic                     out_entry_valid_next;
    logic [ID_W-1:0]          out_id_reg;
    logic [ID_W-1:0]          out_id_next;
    logic [SCORE_W-1:0]       out_score_reg;
    logic [SCORE_W-1:0]       out_score_next;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_next;
    logic                     out_last_reg;
    logic                     out_last_next;

    cell_cmd_t                cmd;
    logic                     slot_free;
    logic                     accept;
    logic                     full;
    logic                     found;
    logic                     load_out;

    // Chain wires, offset by one so that the ends read fixed fillers.
    logic                     go_chain  [0:DEPTH];
    logic                     hit_chain [0:DEPTH];
    logic                     occ_chain [1:DEPTH+1];
    logic [ID_W-1:0]          id_chain  [0:DEPTH+1];
    logic [SCORE_W-1:0]       sc_chain  [0:DEPTH+1];

    assign go_chain[0]         = 1'b0;
    assign hit_chain[0]        = 1'b0;
    assign occ_chain[DEPTH+1]  = 1'b0;
    assign id_chain[0]         = '0;
    assign sc_chain[0]         = '0;
    assign id_chain[DEPTH+1]   = '0;
    assign sc_chain[DEPTH+1]   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dskt_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_go     (go_chain[i]),
            .left_id     (id_chain[i]),
            .left_score  (sc_chain[i]),
            .right_id    (id_chain[i+2]),
            .right_score (sc_chain[i+2]),
            .right_occ   (occ_chain[i+2]),
            .head_id     (id_chain[1]),
            .head_score  (sc_chain[1]),
            .hit_in      (hit_chain[i]),
            .go          (go_chain[i+1]),
            .hit_out     (hit_chain[i+1]),
            .occ         (occ_chain[i+1]),
            .id          (id_chain[i+1]),
            .score       (sc_chain[i+1])
        );
    end

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == FULL_COUNT;
    assign found     = hit_chain[DEPTH];

    always_comb
    begin
        state_next           = state_reg;
        count_next           = count_reg;
        remain_next          = remain_reg;
        out_valid_next       = out_valid_reg && !rsp.ready;
        out_status_next      = out_status_reg;
        out_entry_valid_next = out_entry_valid_reg;
        out_id_next          = out_id_reg;
        out_score_next       = out_score_reg;
        out_count_next       = out_count_reg;
        out_last_next        = out_last_reg;
        load_out             = 1'b0;
        cmd.op               = OP_HOLD;
        cmd.key_id           = req.key_id;
        cmd.score            = req.score;

        if (state_reg == S_LIST)
        begin
            // Emit the head entry and rotate it to the back of the occupied part.
            if (slot_free)
            begin
                cmd.op               = OP_ROTATE;
                load_out             = 1'b1;
                out_status_next      = ST_LIST;
                out_entry_valid_next = 1'b1;
                out_id_next          = id_chain[1];
                out_score_next       = sc_chain[1];
                out_last_next        = remain_reg == ONE;
                remain_next          = remain_reg - ONE;
                if (remain_reg == ONE)
                begin
                    state_next = S_IDLE;
                end
            end
        end
        else if (accept)
        begin
            out_entry_valid_next = 1'b0;
            out_id_next          = '0;
            out_score_next       = '0;
            out_last_next        = 1'b1;
            unique case (func_t'(req.func))
                FN_INSERT:
                begin
                    load_out = 1'b1;
                    if (full)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.op          = OP_INSERT;
                        out_status_next = ST_INSERTED;
                        count_next      = count_reg + ONE;
                    end
                end
                FN_REMOVE:
                begin
                    load_out = 1'b1;
                    cmd.op   = OP_REMOVE;
                    if (found)
                    begin
                        out_status_next = ST_REMOVED;
                        count_next      = count_reg - ONE;
                    end
                    else
                    begin
                        out_status_next = ST_NOT_FOUND;
                    end
                end
                FN_LIST:
                begin
                    if (count_reg == '0)
                    begin
                        load_out        = 1'b1;
                        out_status_next = ST_LIST;
                    end
                    else
                    begin
                        state_next  = S_LIST;
                        remain_next = count_reg;
                    end
                end
                default:
                begin
                    // Unused code: drop the transaction.
                    load_out = 1'b0;
                end
            endcase
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_count_next = ENTRY_COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            count_reg           <= '0;
            remain_reg          <= '0;
            out_valid_reg       <= 1'b0;
            out_status_reg      <= ST_INSERTED;
            out_entry_valid_reg <= 1'b0;
            out_id_reg          <= '0;
            out_score_reg       <= '0;
            out_count_reg       <= '0;
            out_last_reg        <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            count_reg           <= count_next;
            remain_reg          <= remain_next;
            out_valid_reg       <= out_valid_next;
            out_status_reg      <= out_status_next;
            out_entry_valid_reg <= out_entry_valid_next;
            out_id_reg          <= out_id_next;
            out_score_reg       <= out_score_next;
            out_count_reg       <= out_count_next;
            out_last_reg        <= out_last_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_valid = out_entry_valid_reg;
    assign rsp.entry_id    = out_id_reg;
    assign rsp.entry_score = out_score_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last        = out_last_reg;

    `DSKT_ASSERT(a_count_bound, count_reg <= FULL_COUNT, "entry count above table depth")
    `DSKT_ASSERT(a_list_remain, (state_reg == S_LIST) |-> (remain_reg != '0 && remain_reg <= count_reg), "list counter out of range")
    `DSKT_ASSERT(a_full_refused, (accept && req.func == FN_INSERT && full) |=> (rsp.valid && rsp.status == ST_FULL && $stable(count_reg)), "full insert not refused")
    `DSKT_ASSERT(a_plain_last, (rsp.valid && !rsp.entry_valid) |-> rsp.last, "plain result not marked last")

endmodule

// ----- hdl/dskt_cell.sv -----
// One slot of the sorted key chain: holds an entry and trades it with its neighbors.
module dskt_cell import dskt_pkg::*; #(
    parameter int INDEX   = 0,
    parameter int COUNT_W = 6
) (
    input  logic               clk,
    input  cell_cmd_t          cmd,
    input  logic [COUNT_W-1:0] count,
    input  logic               left_go,
    input  logic [ID_W-1:0]    left_id,
    input  logic [SCORE_W-1:0] left_score,
    input  logic [ID_W-1:0]    right_id,
    input  logic [SCORE_W-1:0] right_score,
    input  logic               right_occ,
    input  logic [ID_W-1:0]    head_id,
    input  logic [SCORE_W-1:0] head_score,
    input  logic               hit_in,
    output logic               go,
    output logic               hit_out,
    output logic               occ,
    output logic [ID_W-1:0]    id,
    output logic [SCORE_W-1:0] score
);

    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic               match;

    assign occ     = count > COUNT_W'(INDEX);
    // New entry belongs here or further left: slot empty or strictly lower score.
    assign go      = !occ || (score_reg < cmd.score);
    assign match   = occ && (id_reg == cmd.key_id);
    assign hit_out = hit_in || match;
    assign id      = id_reg;
    assign score   = score_reg;

    always_comb
    begin
        id_next    = id_reg;
        score_next = score_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (left_go)
                begin
                    id_next    = left_id;
                    score_next = left_score;
                end
                else if (go)
                begin
                    id_next    = cmd.key_id;
                    score_next = cmd.score;
                end
            end
            OP_REMOVE:
            begin
                // Close the gap from the first match onward.
                if (hit_out)
                begin
                    id_next    = right_id;
                    score_next = right_score;
                end
            end
            OP_ROTATE:
            begin
                if (occ && !right_occ)
                begin
                    id_next    = head_id;
                    score_next = head_score;
                end
                else if (occ)
                begin
                    id_next    = right_id;
                    score_next = right_score;
                end
            end
            default:
            begin
                id_next    = id_reg;
                score_next = score_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        score_reg <= score_next;
    end

endmodule

// ----- sim/descending_sorted_key_table_top_tb.sv -----
// Self-checking testbench for the descending sorted key table: directed and random traffic.
module descending_sorted_key_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dskt_pkg::*;

    localparam int DEPTH        = 32;
    localparam int CLK_HALF     = 5;
    localparam int MAX_GAP      = 19;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 370;
    localparam int DRAIN_CYCLES = 40;
    // Worst case: every item a list of DEPTH results, each one stalled for the
    // longest sink gap, plus the longest source gap per item; taken a few times over.
    localparam int CYCLE_LIMIT  = 1_200_000;

    // func encoding that the block drops without a result
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef enum logic {
        PH_GROW,
        PH_SHRINK
    } traffic_phase_t;

    // One result transaction as the block should present it.
    typedef struct {
        status_t                  status;
        logic                     entry_valid;
        logic [ID_W-1:0]          entry_id;
        logic [SCORE_W-1:0]       entry_score;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     last;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dskt_req_if req ();
    dskt_rsp_if rsp ();

    descending_sorted_key_table_top #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #CLK_HALF clk = ~clk;

    // Shadow copy of the table, kept in descending score order.
    logic [ID_W-1:0]    held_ids    [DEPTH];
    logic [SCORE_W-1:0] held_scores [DEPTH];
    int                 held_count;

    // Results owed by the block, oldest first.
    table_result_t pending_results [$];

    int mismatches;
    int cycle_count = 0;

    // Idle shaping: each side runs in stretches that are either gap-free or
    // random-gapped, so stalls land on every phase of a list as well as none.
    int src_run;
    bit src_quiet;
    int snk_run;
    bit snk_quiet;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void push_result(status_t st, logic ev, logic [ID_W-1:0] id,
                                        logic [SCORE_W-1:0] sc, logic lst);
        table_result_t r;
        r.status      = st;
        r.entry_valid = ev;
        r.entry_id    = id;
        r.entry_score = sc;
        r.entry_count = ENTRY_COUNT_W'(held_count);
        r.last        = lst;
        pending_results.push_back(r);
    endfunction

    // Update the shadow table for one accepted request and queue what it owes.
    function automatic void predict_table_results(logic [FUNC_W-1:0] fn,
                                                  logic [ID_W-1:0] id,
                                                  logic [SCORE_W-1:0] sc);
        int pos;
        int hit;
        int i;
        case (fn)
            FN_INSERT:
            begin
                if (held_count >= DEPTH)
                begin
                    push_result(ST_FULL, 1'b0, '0, '0, 1'b1);
                end
                else
                begin
                    // new entry goes behind every entry with an equal or higher score
                    pos = 0;
                    while (pos < held_count && held_scores[pos] >= sc)
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_ids[i]    = held_ids[i-1];
                        held_scores[i] = held_scores[i-1];
                    end
                    held_ids[pos]    = id;
                    held_scores[pos] = sc;
                    held_count++;
                    push_result(ST_INSERTED, 1'b0, '0, '0, 1'b1);
                end
            end
            FN_REMOVE:
            begin
                // only the first match in table order goes
                hit = -1;
                for (i = 0; i < held_count; i++)
                    if (hit < 0 && held_ids[i] == id)
                        hit = i;
                if (hit < 0)
                begin
                    push_result(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
                end
                else
                begin
                    for (i = hit; i + 1 < held_count; i++)
                    begin
                        held_ids[i]    = held_ids[i+1];
                        held_scores[i] = held_scores[i+1];
                    end
                    held_count--;
                    push_result(ST_REMOVED, 1'b0, '0, '0, 1'b1);
                end
            end
            FN_LIST:
            begin
                if (held_count == 0)
                    push_result(ST_LIST, 1'b0, '0, '0, 1'b1);
                else
                    for (i = 0; i < held_count; i++)
                        push_result(ST_LIST, 1'b1, held_ids[i], held_scores[i],
                                    i == held_count - 1);
            end
            default:
            begin
                // unused encoding: no result, no change
            end
        endcase
    endfunction

    // Send one request transaction. Entered and left at a falling edge; valid stays
    // high into the next call when that call has no gap.
    task automatic send_request(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                logic [SCORE_W-1:0] sc);
        int gap;
        if (src_run == 0)
        begin
            src_run   = $urandom_range(8, 40);
            src_quiet = ($urandom_range(0, 3) == 0);
        end
        src_run--;
        gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid  <= 1'b1;
        req.func   <= fn;
        req.key_id <= id;
        req.score  <= sc;
        // hold until the block takes it
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_table_results(fn, id, sc);
        @(negedge clk);
    endtask

    // Result side: draw a stall, then raise ready and check the transaction taken.
    initial
    begin : result_checker
        table_result_t want;
        int stall;
        rsp.ready  = 1'b0;
        mismatches = 0;
        snk_run    = 0;
        snk_quiet  = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (snk_run == 0)
            begin
                snk_run   = $urandom_range(8, 40);
                snk_quiet = ($urandom_range(0, 3) == 0);
            end
            snk_run--;
            stall = snk_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("[%0t] unexpected result", $realtime);
                    $display("    actual:   status %0d valid %0b id %h score %h count %0d last %0b",
                             rsp.status, rsp.entry_valid, rsp.entry_id,
                             rsp.entry_score, rsp.entry_count, rsp.last);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.entry_valid !== want.entry_valid ||
                    rsp.entry_id !== want.entry_id || rsp.entry_score !== want.entry_score ||
                    rsp.entry_count !== want.entry_count || rsp.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("[%0t] result mismatch", $realtime);
                        $display("    expected: status %0d valid %0b id %h score %h count %0d last %0b",
                                 want.status, want.entry_valid, want.entry_id,
                                 want.entry_score, want.entry_count, want.last);
                        $display("    actual:   status %0d valid %0b id %h score %h count %0d last %0b",
                                 rsp.status, rsp.entry_valid, rsp.entry_id,
                                 rsp.entry_score, rsp.entry_count, rsp.last);
                    end
                end
            end
            @(negedge clk);
        end
    end

    // Empty table: list, remove with nothing held, and the dropped encoding.
    task automatic test_empty_table();
        send_request(FN_LIST, '0, '0);
        send_request(FN_REMOVE, 32'h1234_5678, '0);
        send_request(FN_UNUSED, $urandom, 16'($urandom));
        send_request(FN_LIST, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Field extremes, equal scores, duplicate ids and a first-match remove.
    task automatic test_extremes_and_ties();
        send_request(FN_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(FN_INSERT, 32'h0000_0000, 16'h0000);
        send_request(FN_INSERT, 32'hA5A5_5A5A, 16'd150);
        // equal score: must land behind the earlier one
        send_request(FN_INSERT, 32'h5A5A_A5A5, 16'd150);
        // duplicate id, ties with the top entry
        send_request(FN_INSERT, 32'hA5A5_5A5A, 16'hFFFF);
        send_request(FN_LIST, '0, '0);
        // drop the first of the duplicates only
        send_request(FN_REMOVE, 32'hA5A5_5A5A, '0);
        send_request(FN_REMOVE, 32'hDEAD_BEEF, '0);
        send_request(FN_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(FN_LIST, '0, '0);
        send_request(FN_REMOVE, 32'hFFFF_FFFF, '0);
        send_request(FN_REMOVE, 32'h0000_0000, '0);
        send_request(FN_REMOVE, 32'h5A5A_A5A5, '0);
        send_request(FN_REMOVE, 32'hA5A5_5A5A, '0);
        send_request(FN_LIST, '0, '0);
    endtask

    // Random traffic in fill and drain phases so the table reaches full, refuses
    // inserts there, and empties again, several times over.
    task automatic test_random_traffic(int n_items);
        traffic_phase_t phase;
        logic [FUNC_W-1:0]  fn;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] sc;
        int roll;
        int done;
        int full_hits;
        int full_target;
        phase       = PH_GROW;
        done        = 0;
        full_hits   = 0;
        full_target = $urandom_range(1, 4);
        while (done < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (phase == PH_GROW)
                fn = (roll < 70) ? FN_INSERT : (roll < 85) ? FN_REMOVE :
                     (roll < 96) ? FN_LIST : FN_UNUSED;
            else
                fn = (roll < 15) ? FN_INSERT : (roll < 80) ? FN_REMOVE :
                     (roll < 95) ? FN_LIST : FN_UNUSED;

            // ids: mostly held ones for remove, some duplicates on insert
            id = $urandom;
            if (held_count > 0)
            begin
                if (fn == FN_REMOVE && $urandom_range(0, 4) != 0)
                    id = held_ids[$urandom_range(0, held_count - 1)];
                else if (fn == FN_INSERT && $urandom_range(0, 7) == 0)
                    id = held_ids[$urandom_range(0, held_count - 1)];
            end

            // scores: a coarse set forces ties and extremes
            case ($urandom_range(0, 3))
                0:       sc = 16'($urandom_range(0, 3)) * 16'h5555;
                1:       sc = 16'($urandom_range(0, 10000));
                default: sc = 16'($urandom);
            endcase

            if (fn == FN_INSERT && held_count == DEPTH)
                full_hits++;
            send_request(fn, id, sc);
            if (fn != FN_UNUSED)
                done++;

            // advance the phase once full has been seen or the table is empty
            if (phase == PH_GROW && full_hits >= full_target)
            begin
                send_request(FN_LIST, '0, '0);
                done++;
                phase     = PH_SHRINK;
                full_hits = 0;
                full_target = $urandom_range(1, 4);
            end
            else if (phase == PH_SHRINK && held_count == 0)
            begin
                phase = PH_GROW;
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.func    = FN_INSERT;
        req.key_id  = '0;
        req.score   = '0;
        held_count  = 0;
        src_run     = 0;
        src_quiet   = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_extremes_and_ties();
        test_random_traffic(RANDOM_ITEMS);

        req.valid <= 1'b0;
        // drain what is still owed, then give the block time to misbehave
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dskt_pkg.sv
hdl/dskt_if.sv
hdl/dskt_cell.sv
hdl/descending_sorted_key_table_top.sv
sim/descending_sorted_key_table_top_tb.sv
